[rtl/tceq_pkg.sv]
// Shared types and constants for the timed current event queue.
package tceq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int TIME_W          = 32;
    localparam int CUR_W           = 16;
    localparam int CNT_OUT_W       = 5;
    localparam int CUR_MAX         = 32767;
    localparam int CUR_MIN         = -32768;

    typedef struct packed {
        logic [TIME_W-1:0]       due_time;
        logic signed [CUR_W-1:0] current;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rd_req;
        logic shift_wr;
        logic ins_wr;
        logic idx_dec;
        logic acc;
        logic fin_add;
        logic fin_drop;
        logic fin_tick;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic idx_zero;
        logic idx_end;
        logic later;
        logic due;
    } stat_t;

endpackage

[rtl/tceq_ctrl.sv]
// Controller state machine for the timed current event queue.
module tceq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           action,
    input  tceq_pkg::stat_t stat,
    output tceq_pkg::cmd_t  cmd,
    output logic           busy
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ADD_RD   = 3'd1;
    localparam logic [2:0] ST_ADD_CMP  = 3'd2;
    localparam logic [2:0] ST_TICK_RD  = 3'd3;
    localparam logic [2:0] ST_TICK_CMP = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = action ? ST_TICK_RD : ST_ADD_RD;
                end
            end
            ST_ADD_RD:
            begin
                if (stat.full)
                begin
                    cmd.fin_drop = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (stat.idx_zero)
                begin
                    cmd.ins_wr  = 1'b1;
                    cmd.fin_add = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.rd_req = 1'b1;
                    state_next = ST_ADD_CMP;
                end
            end
            ST_ADD_CMP:
            begin
                if (stat.later)
                begin
                    cmd.shift_wr = 1'b1;
                    cmd.idx_dec  = 1'b1;
                    state_next   = ST_ADD_RD;
                end
                else
                begin
                    cmd.ins_wr  = 1'b1;
                    cmd.fin_add = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_TICK_RD:
            begin
                if (stat.idx_end)
                begin
                    cmd.fin_tick = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.rd_req = 1'b1;
                    state_next = ST_TICK_CMP;
                end
            end
            ST_TICK_CMP:
            begin
                if (stat.due)
                begin
                    cmd.acc    = 1'b1;
                    state_next = ST_TICK_RD;
                end
                else
                begin
                    cmd.fin_tick = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[rtl/tceq_dp.sv]
// Datapath of the timed current event queue: circular entry memory, counters, accumulator.
module tceq_dp #(
    parameter int QUEUE_DEPTH = tceq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tceq_pkg::cmd_t                       cmd,
    output tceq_pkg::stat_t                      stat,
    input  logic                                 action,
    input  logic [tceq_pkg::TIME_W-1:0]          event_time,
    input  logic signed [tceq_pkg::CUR_W-1:0]    event_current,
    input  logic [tceq_pkg::TIME_W-1:0]          now_time,
    output logic                                 done,
    output logic signed [tceq_pkg::CUR_W-1:0]    summed_current,
    output logic [tceq_pkg::CNT_OUT_W-1:0]       drained_count,
    output logic                                 dropped,
    output logic [tceq_pkg::CNT_OUT_W-1:0]       pending_count
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = tceq_pkg::CUR_W + IDX_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(tceq_pkg::CUR_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(tceq_pkg::CUR_MIN);

    tceq_pkg::entry_t mem [QUEUE_DEPTH];

    tceq_pkg::entry_t                  rd_reg;
    logic [IDX_W-1:0]                  head_reg;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  idx_reg;
    logic signed [SUM_W-1:0]           sum_reg;
    logic                              is_tick_reg;
    logic [tceq_pkg::TIME_W-1:0]       key_reg;
    logic signed [tceq_pkg::CUR_W-1:0] cur_reg;
    logic                              done_reg;
    logic signed [tceq_pkg::CUR_W-1:0] res_sum_reg;
    logic [tceq_pkg::CNT_OUT_W-1:0]    res_drain_reg;
    logic                              res_drop_reg;
    logic [tceq_pkg::CNT_OUT_W-1:0]    res_pend_reg;

    logic [IDX_W-1:0]                  rd_addr;
    logic [IDX_W-1:0]                  wr_addr;
    logic [CNT_W-1:0]                  idx_m1;
    logic                              wr_en;
    tceq_pkg::entry_t                  wr_data;
    logic signed [tceq_pkg::CUR_W-1:0] sat_sum;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = {1'b0, off} + (CNT_W + 1)'(base);
        if (s >= (CNT_W + 1)'(QUEUE_DEPTH))
        begin
            s = s - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign idx_m1  = idx_reg - 1'b1;
    assign rd_addr = is_tick_reg ? wrap_idx(head_reg, idx_reg) : wrap_idx(head_reg, idx_m1);
    assign wr_addr = wrap_idx(head_reg, idx_reg);
    assign wr_en   = cmd.shift_wr | cmd.ins_wr;

    always_comb
    begin
        if (cmd.shift_wr)
        begin
            wr_data = rd_reg;
        end
        else
        begin
            wr_data.due_time = key_reg;
            wr_data.current  = cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_req)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        priority if (sum_reg > SAT_HI)
        begin
            sat_sum = tceq_pkg::CUR_W'(tceq_pkg::CUR_MAX);
        end
        else if (sum_reg < SAT_LO)
        begin
            sat_sum = tceq_pkg::CUR_W'(tceq_pkg::CUR_MIN);
        end
        else
        begin
            sat_sum = sum_reg[tceq_pkg::CUR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_tick_reg <= action;
            key_reg     <= action ? now_time : event_time;
            cur_reg     <= event_current;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.fin_add | cmd.fin_drop | cmd.fin_tick;
            if (cmd.load)
            begin
                idx_reg <= action ? '0 : count_reg;
                sum_reg <= '0;
            end
            if (cmd.idx_dec)
            begin
                idx_reg <= idx_m1;
            end
            if (cmd.acc)
            begin
                idx_reg <= idx_reg + 1'b1;
                sum_reg <= sum_reg + SUM_W'($signed(rd_reg.current));
            end
            if (cmd.fin_add)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.fin_tick)
            begin
                head_reg  <= wrap_idx(head_reg, idx_reg);
                count_reg <= count_reg - idx_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_add)
        begin
            res_sum_reg   <= '0;
            res_drain_reg <= '0;
            res_drop_reg  <= 1'b0;
            res_pend_reg  <= tceq_pkg::CNT_OUT_W'(CNT_W'(count_reg + 1'b1));
        end
        else if (cmd.fin_drop)
        begin
            res_sum_reg   <= '0;
            res_drain_reg <= '0;
            res_drop_reg  <= 1'b1;
            res_pend_reg  <= tceq_pkg::CNT_OUT_W'(count_reg);
        end
        else if (cmd.fin_tick)
        begin
            res_sum_reg   <= sat_sum;
            res_drain_reg <= tceq_pkg::CNT_OUT_W'(idx_reg);
            res_drop_reg  <= 1'b0;
            res_pend_reg  <= tceq_pkg::CNT_OUT_W'(CNT_W'(count_reg - idx_reg));
        end
    end

    assign stat.full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.idx_end  = (idx_reg == count_reg);
    assign stat.later    = (rd_reg.due_time > key_reg);
    assign stat.due      = (rd_reg.due_time <= key_reg);

    assign done           = done_reg;
    assign summed_current = res_sum_reg;
    assign drained_count  = res_drain_reg;
    assign dropped        = res_drop_reg;
    assign pending_count  = res_pend_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_drop |-> stat.full)
        else $error("add dropped while queue has room");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin_add |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("add did not grow the queue by one");

    a_drop_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && res_drop_reg) |-> (res_drain_reg == '0 && res_sum_reg == '0))
        else $error("dropped word carries drain data");

endmodule

[rtl/timed_current_event_queue.sv]
// Top level of the timed current event queue: controller and datapath.
// Add: drops the event if full, else shifts later entries up from the tail and inserts it.
// Tick: drains and sums due entries from the head until a later entry or the queue is empty.
// done pulses in the cycle after the last step; busy is low again in that cycle.
// Reset (rst_n low, asynchronous) empties the queue and returns to idle.
// The receiver cannot stall: each result word is valid only while done is high.
module timed_current_event_queue #(
    parameter int QUEUE_DEPTH = tceq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [tceq_pkg::TIME_W-1:0]       event_time,
    input  logic signed [tceq_pkg::CUR_W-1:0] event_current,
    input  logic [tceq_pkg::TIME_W-1:0]       now_time,
    output logic                              done,
    output logic signed [tceq_pkg::CUR_W-1:0] summed_current,
    output logic [tceq_pkg::CNT_OUT_W-1:0]    drained_count,
    output logic                              dropped,
    output logic [tceq_pkg::CNT_OUT_W-1:0]    pending_count
);

    tceq_pkg::cmd_t  cmd;
    tceq_pkg::stat_t stat;

    tceq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    tceq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .action         (action),
        .event_time     (event_time),
        .event_current  (event_current),
        .now_time       (now_time),
        .done           (done),
        .summed_current (summed_current),
        .drained_count  (drained_count),
        .dropped        (dropped),
        .pending_count  (pending_count)
    );

endmodule
